/* src/ppghr_pkg.sv */
// Shared types and constants for the PPG heart rate detector.
package ppghr_pkg;

  // Field widths
  localparam int SAMPLE_BITS   = 18;
  localparam int FRAC_BITS     = 8;
  localparam int BASE_BITS     = SAMPLE_BITS + FRAC_BITS;
  localparam int COEF_BITS     = 16;
  localparam int PROD_BITS     = BASE_BITS + COEF_BITS;
  localparam int TIME_BITS     = 32;
  localparam int INTERVAL_BITS = 16;
  localparam int BPM_BITS      = 16;
  localparam int CFG_BITS      = 18;
  localparam int CFG_IDX_BITS  = 2;
  localparam int DIV_CNT_BITS  = $clog2(BPM_BITS + 1);

  // Q0.16 coefficients: 0.9, 0.1, 0.02 and the rounding half
  localparam logic [COEF_BITS-1:0] COEF_KEEP = 16'd58982;
  localparam logic [COEF_BITS-1:0] COEF_NEW  = 16'd6554;
  localparam logic [COEF_BITS-1:0] COEF_THR  = 16'd1311;
  localparam logic [PROD_BITS:0]   COEF_HALF = (PROD_BITS+1)'(32768);

  // Rate numerator, ms per minute
  localparam logic [BPM_BITS-1:0] BPM_NUMERATOR = 16'd60000;

  // Register reset values
  localparam logic [SAMPLE_BITS-1:0]   FINGER_THRESHOLD_RST = 18'd15000;
  localparam logic [SAMPLE_BITS-1:0]   THRESHOLD_FLOOR_RST  = 18'd1000;
  localparam logic [INTERVAL_BITS-1:0] MIN_INTERVAL_RST     = 16'd300;
  localparam logic [INTERVAL_BITS-1:0] MAX_INTERVAL_RST     = 16'd2000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FINGER_THRESHOLD = 2'd0,
    REG_THRESHOLD_FLOOR  = 2'd1,
    REG_MIN_INTERVAL     = 2'd2,
    REG_MAX_INTERVAL     = 2'd3
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_KEEP,
    S_MUL_NEW,
    S_MUL_SUM,
    S_MUL_THR,
    S_THR,
    S_EDGE,
    S_WINDOW,
    S_DIVIDE,
    S_DONE
  } state_t;

endpackage

/* src/ppg_heart_rate_detector.sv */
// PPG heart rate detector: baseline tracking, pulse edge detection and rate.
// After acceptance an item without a finger goes straight to the result; one with a finger
// runs the baseline update, threshold and edge test, and a new beat that falls inside the
// interval window also runs the divider. The next item is accepted only after the result
// is loaded, which waits while the previous result is stalled. The shared multiplier runs
// three products in turn and the serial divider takes one cycle per quotient bit. Synchronous
// reset restores register defaults and clears baseline, edge flag, rate and last beat time.
module ppg_heart_rate_detector (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  cfg_write,
  input  logic [ppghr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [ppghr_pkg::CFG_BITS-1:0]        cfg_data,
  // input samples
  input  logic                                  sample_valid,
  output logic                                  sample_stall,
  input  logic [ppghr_pkg::SAMPLE_BITS-1:0]     red_sample,
  input  logic [ppghr_pkg::SAMPLE_BITS-1:0]     ir_sample,
  input  logic [ppghr_pkg::TIME_BITS-1:0]       time_ms,
  // results
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic [ppghr_pkg::SAMPLE_BITS-1:0]     red_out,
  output logic [ppghr_pkg::SAMPLE_BITS-1:0]     ir_out,
  output logic                                  finger_detected,
  output logic [ppghr_pkg::BPM_BITS-1:0]        beats_per_minute
);

  ppghr_pkg::state_t state, state_next;

  // configuration registers
  logic [ppghr_pkg::SAMPLE_BITS-1:0]   finger_threshold;
  logic [ppghr_pkg::SAMPLE_BITS-1:0]   threshold_floor;
  logic [ppghr_pkg::INTERVAL_BITS-1:0] min_interval;
  logic [ppghr_pkg::INTERVAL_BITS-1:0] max_interval;

  // detector state
  logic [ppghr_pkg::BASE_BITS-1:0]     baseline;
  logic                                was_above;
  logic [ppghr_pkg::BPM_BITS-1:0]      rate;
  logic [ppghr_pkg::TIME_BITS-1:0]     last_beat_time;

  // item in work
  logic [ppghr_pkg::SAMPLE_BITS-1:0]   red;
  logic [ppghr_pkg::SAMPLE_BITS-1:0]   ir;
  logic [ppghr_pkg::TIME_BITS-1:0]     now;
  logic                                finger;
  logic [ppghr_pkg::PROD_BITS-1:0]     acc;
  logic [ppghr_pkg::BASE_BITS-1:0]     thr;
  logic [ppghr_pkg::TIME_BITS-1:0]     dt;

  logic                                accept;
  logic                                finger_in;
  logic [ppghr_pkg::BASE_BITS-1:0]     ir_in_fx;
  logic [ppghr_pkg::BASE_BITS-1:0]     ir_fx;
  logic [ppghr_pkg::BASE_BITS-1:0]     mac_operand;
  logic [ppghr_pkg::COEF_BITS-1:0]     mac_coef;
  logic [ppghr_pkg::PROD_BITS-1:0]     product;
  logic [ppghr_pkg::PROD_BITS:0]       base_sum;
  logic [ppghr_pkg::PROD_BITS:0]       thr_sum;
  logic [ppghr_pkg::BASE_BITS-1:0]     thr_rnd;
  logic [ppghr_pkg::BASE_BITS-1:0]     floor_fx;
  logic [ppghr_pkg::BASE_BITS:0]       level;
  logic                                above;
  logic                                in_window;
  logic                                div_start;
  logic                                div_busy;
  logic [ppghr_pkg::BPM_BITS-1:0]      div_quotient;
  logic                                out_load;

  assign sample_stall = (state != ppghr_pkg::S_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign finger_in    = (ir_sample >= finger_threshold);
  assign ir_in_fx     = {ir_sample, ppghr_pkg::FRAC_BITS'(0)};
  assign ir_fx        = {ir, ppghr_pkg::FRAC_BITS'(0)};

  // Rounded baseline update and threshold
  assign base_sum = {1'b0, acc} + {1'b0, product} + ppghr_pkg::COEF_HALF;
  assign thr_sum  = {1'b0, product} + ppghr_pkg::COEF_HALF;
  assign thr_rnd  = thr_sum[ppghr_pkg::BASE_BITS+15:16];
  assign floor_fx = {threshold_floor, ppghr_pkg::FRAC_BITS'(0)};

  // Pulse level and interval window
  assign level     = {1'b0, baseline} + {1'b0, thr};
  assign above     = {1'b0, ir_fx} > level;
  assign in_window = (dt > ppghr_pkg::TIME_BITS'(min_interval)) &&
                     (dt < ppghr_pkg::TIME_BITS'(max_interval));

  ppghr_mac u_mac (
    .clk     (clk),
    .operand (mac_operand),
    .coef    (mac_coef),
    .product (product)
  );

  ppghr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (dt[ppghr_pkg::INTERVAL_BITS-1:0]),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppghr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state, multiplier operand and coefficient select, divider start and output load
  always_comb begin
    state_next  = state;
    mac_operand = baseline;
    mac_coef    = ppghr_pkg::COEF_THR;
    div_start   = 1'b0;
    out_load    = 1'b0;
    unique case (state)
      ppghr_pkg::S_IDLE: begin
        if (accept) begin
          state_next = finger_in ? ppghr_pkg::S_MUL_KEEP : ppghr_pkg::S_DONE;
        end
      end
      ppghr_pkg::S_MUL_KEEP: begin
        mac_coef   = ppghr_pkg::COEF_KEEP;
        state_next = ppghr_pkg::S_MUL_NEW;
      end
      ppghr_pkg::S_MUL_NEW: begin
        mac_operand = ir_fx;
        mac_coef    = ppghr_pkg::COEF_NEW;
        state_next  = ppghr_pkg::S_MUL_SUM;
      end
      ppghr_pkg::S_MUL_SUM: begin
        state_next = ppghr_pkg::S_MUL_THR;
      end
      ppghr_pkg::S_MUL_THR: begin
        state_next = ppghr_pkg::S_THR;
      end
      ppghr_pkg::S_THR: begin
        state_next = ppghr_pkg::S_EDGE;
      end
      ppghr_pkg::S_EDGE: begin
        state_next = (above && !was_above) ? ppghr_pkg::S_WINDOW : ppghr_pkg::S_DONE;
      end
      ppghr_pkg::S_WINDOW: begin
        div_start  = in_window;
        state_next = in_window ? ppghr_pkg::S_DIVIDE : ppghr_pkg::S_DONE;
      end
      ppghr_pkg::S_DIVIDE: begin
        if (!div_busy) begin
          state_next = ppghr_pkg::S_DONE;
        end
      end
      ppghr_pkg::S_DONE: begin
        if (!result_valid || !result_stall) begin
          out_load   = 1'b1;
          state_next = ppghr_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ppghr_pkg::S_IDLE;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      finger_threshold <= ppghr_pkg::FINGER_THRESHOLD_RST;
      threshold_floor  <= ppghr_pkg::THRESHOLD_FLOOR_RST;
      min_interval     <= ppghr_pkg::MIN_INTERVAL_RST;
      max_interval     <= ppghr_pkg::MAX_INTERVAL_RST;
    end else if (cfg_write) begin
      unique case (ppghr_pkg::cfg_reg_t'(cfg_index))
        ppghr_pkg::REG_FINGER_THRESHOLD: finger_threshold <= cfg_data;
        ppghr_pkg::REG_THRESHOLD_FLOOR:  threshold_floor  <= cfg_data;
        ppghr_pkg::REG_MIN_INTERVAL:
          min_interval <= cfg_data[ppghr_pkg::INTERVAL_BITS-1:0];
        ppghr_pkg::REG_MAX_INTERVAL:
          max_interval <= cfg_data[ppghr_pkg::INTERVAL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Detector state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      baseline       <= '0;
      was_above      <= 1'b0;
      rate           <= '0;
      last_beat_time <= '0;
    end else begin
      unique case (state)
        ppghr_pkg::S_IDLE: begin
          if (accept) begin
            if (!finger_in) begin
              baseline  <= '0;
              was_above <= 1'b0;
              rate      <= '0;
            end else if (baseline == '0) begin
              baseline <= ir_in_fx;
            end
          end
        end
        ppghr_pkg::S_MUL_SUM: begin
          baseline <= base_sum[ppghr_pkg::BASE_BITS+15:16];
        end
        ppghr_pkg::S_EDGE: begin
          was_above <= above;
          if (above && !was_above) begin
            last_beat_time <= now;
          end
        end
        ppghr_pkg::S_DIVIDE: begin
          if (!div_busy) begin
            rate <= div_quotient;
          end
        end
        default: ;
      endcase
    end
  end

  // Item working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      red    <= red_sample;
      ir     <= ir_sample;
      now    <= time_ms;
      finger <= finger_in;
    end
    if (state == ppghr_pkg::S_MUL_NEW) begin
      acc <= product;
    end
    // threshold, raised to the floor
    if (state == ppghr_pkg::S_THR) begin
      thr <= (thr_rnd < floor_fx) ? floor_fx : thr_rnd;
    end
    // wrapping interval since the last beat
    if (state == ppghr_pkg::S_EDGE) begin
      dt <= now - last_beat_time;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      red_out          <= red;
      ir_out           <= ir;
      finger_detected  <= finger;
      beats_per_minute <= rate;
    end
  end

endmodule

/* src/ppghr_mac.sv */
// Shared registered multiplier: baseline-format operand times Q0.16 coefficient.
module ppghr_mac (
  input  logic                                clk,
  input  logic [ppghr_pkg::BASE_BITS-1:0]     operand,
  input  logic [ppghr_pkg::COEF_BITS-1:0]     coef,
  output logic [ppghr_pkg::PROD_BITS-1:0]     product
);

  // One product per cycle, registered
  always_ff @(posedge clk) begin
    product <= ppghr_pkg::PROD_BITS'(operand) * ppghr_pkg::PROD_BITS'(coef);
  end

endmodule

/* src/ppghr_div.sv */
// Restoring serial divider: constant numerator over a 16-bit interval, one bit per cycle.
module ppghr_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [ppghr_pkg::INTERVAL_BITS-1:0]  divisor,
  output logic                                 busy,
  output logic [ppghr_pkg::BPM_BITS-1:0]       quotient
);

  logic [ppghr_pkg::INTERVAL_BITS-1:0] dvsr;
  logic [ppghr_pkg::INTERVAL_BITS-1:0] rem;
  logic [ppghr_pkg::BPM_BITS-1:0]      quo;
  logic [ppghr_pkg::DIV_CNT_BITS-1:0]  count;
  logic [ppghr_pkg::INTERVAL_BITS:0]   trial;
  logic                                fits;

  // One quotient bit: shift in the next numerator bit and try the subtract
  assign trial = {rem, quo[ppghr_pkg::BPM_BITS-1]};
  assign fits  = trial >= {1'b0, dvsr};

  assign busy     = (count != '0);
  assign quotient = quo;

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= ppghr_pkg::DIV_CNT_BITS'(ppghr_pkg::BPM_BITS);
    end else if (busy) begin
      count <= count - 1'b1;
    end
  end

  // Remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      dvsr <= divisor;
      rem  <= '0;
      quo  <= ppghr_pkg::BPM_NUMERATOR;
    end else if (busy) begin
      if (fits) begin
        rem <= ppghr_pkg::INTERVAL_BITS'(trial - {1'b0, dvsr});
      end else begin
        rem <= trial[ppghr_pkg::INTERVAL_BITS-1:0];
      end
      quo <= {quo[ppghr_pkg::BPM_BITS-2:0], fits};
    end
  end

endmodule
